// ----- hw/rtl/blbx_pkg.sv -----
// ----------------------------------------------------------------------------
// blbx_pkg - shared types and constants for the gray-level bounding box
// Register indexes, control and box structs, and gray-level constants.
// ----------------------------------------------------------------------------
package blbx_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TARGET_GRAY  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } blbx_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int GRAY_W     = 8;
  localparam int BOX_W      = 12;

  // Divide-by-three of the channel sum: floor(s * 683 / 2048) is exact for s <= 765
  localparam int SUM_W       = 10;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;
  localparam int RECIP_W     = 10;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // Control from the top level to the tracker
  typedef struct packed {
    logic step;   // one pixel leaves the input register
    logic hit;    // its gray level equals the target
    logic rearm;  // frame size written, restart the frame
  } blbx_ctl_t;

  // Finished box, widened by one on every side
  typedef struct packed {
    logic [BOX_W-1:0] low_x;
    logic [BOX_W-1:0] low_y;
    logic [BOX_W-1:0] high_x;
    logic [BOX_W-1:0] high_y;
  } blbx_box_t;

endpackage

// ----- hw/rtl/gray_level_bounding_box_core.sv -----
// ----------------------------------------------------------------------------
// gray_level_bounding_box_core - bounding box of one gray level per frame
// Raster pixel stream in, one widened bounding box out per frame.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-----------------------------------
//  in_      | in        | in_valid / in_stall  | in_blue, in_green, in_red
//  out_     | out       | out_valid / out_stall| out_low_x, out_low_y, out_high_x,
//           |           |                      | out_high_y, out_box_gray
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One pixel per clock sustained while out_stall is low. A pixel transfer lands
//  in the input register; as it advances it is folded into the tracker and, on
//  the last pixel of a frame, the box is loaded into the output register, which
//  drives out_valid. While a box waits, one more pixel is taken into the input
//  register; in_stall rises only when a pixel is held in the input register
//  behind a stalled box. cfg_ready is always high. Reset (rst_n low,
//  synchronous) empties both registers and restores 640 x 480 frames and target
//  gray 0.
//
// ----------------------------------------------------------------------------
module gray_level_bounding_box_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [blbx_pkg::GRAY_W-1:0]         in_blue,
  input  logic [blbx_pkg::GRAY_W-1:0]         in_green,
  input  logic [blbx_pkg::GRAY_W-1:0]         in_red,
  // box output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [blbx_pkg::BOX_W-1:0]   out_low_x,
  output logic signed [blbx_pkg::BOX_W-1:0]   out_low_y,
  output logic [blbx_pkg::BOX_W-1:0]          out_high_x,
  output logic [blbx_pkg::BOX_W-1:0]          out_high_y,
  output logic [blbx_pkg::GRAY_W-1:0]         out_box_gray,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [blbx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blbx_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Position counters hold 0..MAX-1, dimensions and minima hold up to MAX
  localparam int XP_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YP_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XD_W  = $clog2(MAX_WIDTH + 1);
  localparam int YD_W  = $clog2(MAX_HEIGHT + 1);
  localparam int XC_W  = (XD_W > blbx_pkg::CFG_DATA_W) ? XD_W : blbx_pkg::CFG_DATA_W;
  localparam int YC_W  = (YD_W > blbx_pkg::CFG_DATA_W) ? YD_W : blbx_pkg::CFG_DATA_W;
  localparam int RST_W = (640 > MAX_WIDTH)  ? MAX_WIDTH  : 640;
  localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  // configuration registers
  logic [blbx_pkg::GRAY_W-1:0] target_gray_r, target_gray_nxt;
  logic [XD_W-1:0]             frame_width_r, frame_width_nxt;
  logic [YD_W-1:0]             frame_height_r, frame_height_nxt;
  logic [XD_W-1:0]             width_clamp;
  logic [YD_W-1:0]             height_clamp;
  logic                        cfg_wr;
  logic                        rearm;

  // input register
  logic                        pix_vld_r, pix_vld_nxt;
  logic [blbx_pkg::GRAY_W-1:0] gray_r;
  logic [blbx_pkg::GRAY_W-1:0] gray_in;
  logic                        in_xfer;
  logic                        adv;

  // output register
  logic                        out_vld_r, out_vld_nxt;
  blbx_pkg::blbx_box_t         box_r;
  logic [blbx_pkg::GRAY_W-1:0] box_gray_r;

  blbx_pkg::blbx_ctl_t         ctl;
  blbx_pkg::blbx_box_t         box;
  logic                        box_vld;

  // --------------------------------------------------------------------------
  // Configuration: frame sizes are clamped to 1..MAX; a size write restarts
  // the frame, a target write does not.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      width_clamp = XD_W'(1);
    end else if (XC_W'(cfg_data) > XC_W'(MAX_WIDTH)) begin
      width_clamp = XD_W'(MAX_WIDTH);
    end else begin
      width_clamp = XD_W'(cfg_data);
    end
    if (cfg_data == '0) begin
      height_clamp = YD_W'(1);
    end else if (YC_W'(cfg_data) > YC_W'(MAX_HEIGHT)) begin
      height_clamp = YD_W'(MAX_HEIGHT);
    end else begin
      height_clamp = YD_W'(cfg_data);
    end
  end

  always_comb begin
    target_gray_nxt  = target_gray_r;
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    rearm            = 1'b0;
    if (cfg_wr) begin
      case (cfg_index)
        blbx_pkg::REG_TARGET_GRAY: begin
          target_gray_nxt = cfg_data[blbx_pkg::GRAY_W-1:0];
        end
        blbx_pkg::REG_FRAME_WIDTH: begin
          frame_width_nxt = width_clamp;
          rearm           = 1'b1;
        end
        blbx_pkg::REG_FRAME_HEIGHT: begin
          frame_height_nxt = height_clamp;
          rearm            = 1'b1;
        end
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pixel path: gray level computed at the port, registered, then folded in.
  // The held pixel moves on whenever the output register is free or draining.
  // --------------------------------------------------------------------------
  blbx_gray u_gray (
    .blue  (in_blue),
    .green (in_green),
    .red   (in_red),
    .gray  (gray_in)
  );

  assign adv      = pix_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = pix_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign ctl.step  = adv;
  assign ctl.hit   = adv && (gray_r == target_gray_r);
  assign ctl.rearm = rearm;

  always_comb begin
    pix_vld_nxt = pix_vld_r;
    if (in_xfer) begin
      pix_vld_nxt = 1'b1;
    end else if (adv) begin
      pix_vld_nxt = 1'b0;
    end
  end

  blbx_track #(
    .XP_W  (XP_W),
    .XD_W  (XD_W),
    .YP_W  (YP_W),
    .YD_W  (YD_W),
    .RST_W (RST_W),
    .RST_H (RST_H)
  ) u_track (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .width_nxt    (frame_width_nxt),
    .height_nxt   (frame_height_nxt),
    .box          (box),
    .box_vld      (box_vld)
  );

  // --------------------------------------------------------------------------
  // Output register: loaded with the closed box, held until its transfer.
  // --------------------------------------------------------------------------
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (box_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_gray_r  <= '0;
      frame_width_r  <= XD_W'(RST_W);
      frame_height_r <= YD_W'(RST_H);
      pix_vld_r      <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      target_gray_r  <= target_gray_nxt;
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      pix_vld_r      <= pix_vld_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      gray_r <= gray_in;
    end
    if (box_vld) begin
      box_r      <= box;
      box_gray_r <= target_gray_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_low_x    = $signed(box_r.low_x);
  assign out_low_y    = $signed(box_r.low_y);
  assign out_high_x   = box_r.high_x;
  assign out_high_y   = box_r.high_y;
  assign out_box_gray = box_gray_r;

`ifndef SYNTHESIS
  // a box is only closed when the output register can take it
  a_box_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    box_vld |-> (!out_vld_r || !out_stall))
    else $error("box closed while output register still held a stalled box");

  // a closed box shows up on the output the next cycle
  a_box_presented: assert property (@(posedge clk) disable iff (!rst_n)
    box_vld |=> out_valid)
    else $error("closed box not presented on the output");

  // the input only backs up behind a stalled box
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && pix_vld_r))
    else $error("input stalled without a stalled box downstream");
`endif

endmodule

// ----- hw/rtl/blbx_gray.sv -----
// ----------------------------------------------------------------------------
// blbx_gray - gray level of one pixel
// Truncated mean of the three channel bytes, by reciprocal multiply.
// ----------------------------------------------------------------------------
module blbx_gray (
  input  logic [blbx_pkg::GRAY_W-1:0] blue,
  input  logic [blbx_pkg::GRAY_W-1:0] green,
  input  logic [blbx_pkg::GRAY_W-1:0] red,
  output logic [blbx_pkg::GRAY_W-1:0] gray
);

  logic [blbx_pkg::SUM_W-1:0]  sum;
  logic [blbx_pkg::PROD_W-1:0] prod;

  assign sum  = blbx_pkg::SUM_W'(blue) + blbx_pkg::SUM_W'(green) + blbx_pkg::SUM_W'(red);
  assign prod = blbx_pkg::PROD_W'(sum) *
                blbx_pkg::PROD_W'(blbx_pkg::GRAY_RECIP);
  // sum / 3 never exceeds 255
  assign gray = prod[blbx_pkg::GRAY_SHIFT +: blbx_pkg::GRAY_W];

endmodule

// ----- hw/rtl/blbx_track.sv -----
// ----------------------------------------------------------------------------
// blbx_track - raster position and bounding box tracker
// Counts column and row, folds matching pixels into min/max, closes the box.
// ----------------------------------------------------------------------------
module blbx_track #(
  parameter int XP_W  = 11,
  parameter int XD_W  = 12,
  parameter int YP_W  = 11,
  parameter int YD_W  = 12,
  parameter int RST_W = 640,
  parameter int RST_H = 480
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  blbx_pkg::blbx_ctl_t  ctl,
  input  logic [XD_W-1:0]      frame_width,
  input  logic [YD_W-1:0]      frame_height,
  input  logic [XD_W-1:0]      width_nxt,
  input  logic [YD_W-1:0]      height_nxt,
  output blbx_pkg::blbx_box_t  box,
  output logic                 box_vld
);

  localparam int XE_W = (XD_W > blbx_pkg::BOX_W) ? XD_W : blbx_pkg::BOX_W;
  localparam int YE_W = (YD_W > blbx_pkg::BOX_W) ? YD_W : blbx_pkg::BOX_W;

  logic [XP_W-1:0] col_pos_r, col_pos_nxt;
  logic [YP_W-1:0] row_pos_r, row_pos_nxt;
  logic [XD_W-1:0] col_min_r, col_min_nxt;
  logic [YD_W-1:0] row_min_r, row_min_nxt;
  logic [XP_W-1:0] col_max_r, col_max_nxt;
  logic [YP_W-1:0] row_max_r, row_max_nxt;

  logic [XD_W-1:0] u_col_min;
  logic [YD_W-1:0] u_row_min;
  logic [XP_W-1:0] u_col_max;
  logic [YP_W-1:0] u_row_max;
  logic            last_col;
  logic            last_row;
  logic [XE_W-1:0] low_x_ext, high_x_ext;
  logic [YE_W-1:0] low_y_ext, high_y_ext;

  // min/max with the current pixel folded in
  always_comb begin
    u_col_min = col_min_r;
    u_row_min = row_min_r;
    u_col_max = col_max_r;
    u_row_max = row_max_r;
    if (ctl.hit) begin
      if (XD_W'(col_pos_r) < col_min_r) u_col_min = XD_W'(col_pos_r);
      if (YD_W'(row_pos_r) < row_min_r) u_row_min = YD_W'(row_pos_r);
      if (col_pos_r > col_max_r) u_col_max = col_pos_r;
      if (row_pos_r > row_max_r) u_row_max = row_pos_r;
    end
  end

  assign last_col = ((XD_W+1)'(col_pos_r) + (XD_W+1)'(1)) >= (XD_W+1)'(frame_width);
  assign last_row = ((YD_W+1)'(row_pos_r) + (YD_W+1)'(1)) >= (YD_W+1)'(frame_height);
  assign box_vld  = ctl.step && last_col && last_row;

  assign low_x_ext  = XE_W'(u_col_min) - XE_W'(1);
  assign low_y_ext  = YE_W'(u_row_min) - YE_W'(1);
  assign high_x_ext = XE_W'(u_col_max) + XE_W'(1);
  assign high_y_ext = YE_W'(u_row_max) + YE_W'(1);

  assign box.low_x  = low_x_ext[blbx_pkg::BOX_W-1:0];
  assign box.low_y  = low_y_ext[blbx_pkg::BOX_W-1:0];
  assign box.high_x = high_x_ext[blbx_pkg::BOX_W-1:0];
  assign box.high_y = high_y_ext[blbx_pkg::BOX_W-1:0];

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    col_min_nxt = col_min_r;
    row_min_nxt = row_min_r;
    col_max_nxt = col_max_r;
    row_max_nxt = row_max_r;
    if (ctl.rearm) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
      col_min_nxt = width_nxt;
      row_min_nxt = height_nxt;
      col_max_nxt = '0;
      row_max_nxt = '0;
    end else if (ctl.step) begin
      if (last_col && last_row) begin
        col_pos_nxt = '0;
        row_pos_nxt = '0;
        col_min_nxt = frame_width;
        row_min_nxt = frame_height;
        col_max_nxt = '0;
        row_max_nxt = '0;
      end else begin
        col_min_nxt = u_col_min;
        row_min_nxt = u_row_min;
        col_max_nxt = u_col_max;
        row_max_nxt = u_row_max;
        if (last_col) begin
          col_pos_nxt = '0;
          row_pos_nxt = row_pos_r + YP_W'(1);
        end else begin
          col_pos_nxt = col_pos_r + XP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      col_min_r <= XD_W'(RST_W);
      row_min_r <= YD_W'(RST_H);
      col_max_r <= '0;
      row_max_r <= '0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      col_min_r <= col_min_nxt;
      row_min_r <= row_min_nxt;
      col_max_r <= col_max_nxt;
      row_max_r <= row_max_nxt;
    end
  end

endmodule
